// ----- design/vrxy_pkg.sv -----
// Shared types, constants and the sine table builder for the vertex rotate unit.
`default_nettype none

package vrxy_pkg;

   localparam int AngleWidth   = 9;
   localparam int QuarterIdxW  = 7;
   localparam int QuarterLast  = 90;

   localparam logic [AngleWidth-1:0] AngQuarter   = 9'd90;
   localparam logic [AngleWidth-1:0] AngHalf      = 9'd180;
   localparam logic [AngleWidth-1:0] AngThreeQtr  = 9'd270;
   localparam logic [AngleWidth-1:0] AngFullTurn  = 9'd360;

   localparam logic [63:0] PiQ52 = 64'h003243F6A8885A31;

   typedef enum logic [0:0] {
      CsrAngleX = 1'b0,
      CsrAngleY = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                   neg;
      logic [QuarterIdxW-1:0] idx;
   } quarter_ref_type;

   // sine of a whole degree in 0..90, Q31 Taylor series, rounded to frac bits
   function automatic logic [63:0] sin_quarter(input int deg, input int frac);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      sum;
      int          k;
      int          sh;
      x    = ((64'(deg) * PiQ52) / 64'd180 + (64'd1 << 20)) >> 21;
      x2   = (x * x) >> 31;
      term = x;
      sum  = longint'(x);
      for (k = 1; k <= 8; k++) begin
         term = ((term * x2) >> 31) / 64'((2 * k) * (2 * k + 1));
         if ((k % 2) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      sh = 31 - frac;
      return (64'(sum) + (64'd1 << (sh - 1))) >> sh;
   endfunction

   // fold an angle in 0..359 onto the quarter wave
   function automatic quarter_ref_type fold_angle(input logic [AngleWidth-1:0] a);
      quarter_ref_type r;
      if (a <= AngQuarter) begin
         r.neg = 1'b0;
         r.idx = a[QuarterIdxW-1:0];
      end else if (a <= AngHalf) begin
         r.neg = 1'b0;
         r.idx = QuarterIdxW'(AngHalf - a);
      end else if (a <= AngThreeQtr) begin
         r.neg = 1'b1;
         r.idx = QuarterIdxW'(a - AngHalf);
      end else begin
         r.neg = 1'b1;
         r.idx = QuarterIdxW'(AngFullTurn - a);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- design/vrxy_trig_lut.sv -----
// Degree to sine and cosine lookup over a quarter-wave constant table.
`default_nettype none

module vrxy_trig_lut #(
   parameter int TRIG_FRAC_BITS = 14
) (
   input  wire logic [vrxy_pkg::AngleWidth-1:0] angle,
   output logic signed [TRIG_FRAC_BITS+1:0]     sin_val,
   output logic signed [TRIG_FRAC_BITS+1:0]     cos_val
);

   localparam int TW = TRIG_FRAC_BITS + 2;
   localparam int QW = TRIG_FRAC_BITS + 1;

   logic [QW-1:0]                   quarter [0:vrxy_pkg::QuarterLast];
   logic [vrxy_pkg::AngleWidth-1:0] ang_wrap;
   logic [vrxy_pkg::AngleWidth-1:0] ang_cos;
   vrxy_pkg::quarter_ref_type       sin_ref;
   vrxy_pkg::quarter_ref_type       cos_ref;
   logic signed [TW-1:0]            sin_mag;
   logic signed [TW-1:0]            cos_mag;

   for (genvar d = 0; d <= vrxy_pkg::QuarterLast; d++) begin : g_quarter
      assign quarter[d] = QW'(vrxy_pkg::sin_quarter(d, TRIG_FRAC_BITS));
   end

   always_comb begin
      ang_wrap = (angle >= vrxy_pkg::AngFullTurn) ? angle - vrxy_pkg::AngFullTurn : angle;
      ang_cos  = ang_wrap + vrxy_pkg::AngQuarter;
      if (ang_cos >= vrxy_pkg::AngFullTurn) begin
         ang_cos = ang_cos - vrxy_pkg::AngFullTurn;
      end
      sin_ref = vrxy_pkg::fold_angle(ang_wrap);
      cos_ref = vrxy_pkg::fold_angle(ang_cos);
      sin_mag = signed'({1'b0, quarter[sin_ref.idx]});
      cos_mag = signed'({1'b0, quarter[cos_ref.idx]});
      sin_val = sin_ref.neg ? -sin_mag : sin_mag;
      cos_val = cos_ref.neg ? -cos_mag : cos_mag;
   end

endmodule

`default_nettype wire

// ----- design/vertex_rotate_x_then_y_unit.sv -----
// Top level: four-stage pipeline rotating a fixed-point vertex about X, then about Y.
//
//   channel   ports                                  handshake
//   request   req_vx, req_vy, req_vz                 start / busy
//   response  rsp_rx, rsp_ry, rsp_rz                 rsp_valid strobe, one cycle
//   csr       csr_index, csr_wdata                   csr_we, no wait
//
// One vertex enters every cycle while busy is low; its result passes through the two
// multiply stages, each followed by an add-and-round stage, before rsp_valid marks it.
// Busy is high in reset and the cycle after it, low otherwise.
// Reset clears the valid bits and sets both angles to zero.
// The receiver takes every response beat; nothing stalls the pipeline.
`default_nettype none

module vertex_rotate_x_then_y_unit #(
   parameter int COORD_WIDTH    = 16,
   parameter int TRIG_FRAC_BITS = 14
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic signed [COORD_WIDTH-1:0]     req_vx,
   input  wire logic signed [COORD_WIDTH-1:0]     req_vy,
   input  wire logic signed [COORD_WIDTH-1:0]     req_vz,
   output logic                                   rsp_valid,
   output logic signed [COORD_WIDTH-1:0]          rsp_rx,
   output logic signed [COORD_WIDTH-1:0]          rsp_ry,
   output logic signed [COORD_WIDTH-1:0]          rsp_rz,
   input  wire logic                              csr_we,
   input  wire logic [0:0]                        csr_index,
   input  wire logic [vrxy_pkg::AngleWidth-1:0]   csr_wdata
);

   localparam int W   = COORD_WIDTH;
   localparam int TW  = TRIG_FRAC_BITS + 2;
   localparam int P1W = W + TW;
   localparam int S1W = P1W + 1;
   localparam int Y1W = W + 2;
   localparam int P2W = Y1W + TW;
   localparam int S2W = P2W + 1;

   localparam logic signed [TW-1:0]  TrigOne =
      TW'(vrxy_pkg::sin_quarter(vrxy_pkg::QuarterLast, TRIG_FRAC_BITS));
   localparam logic signed [S1W-1:0] Half1 = S1W'(1) <<< (TRIG_FRAC_BITS - 1);
   localparam logic signed [S2W-1:0] Half2 = S2W'(1) <<< (TRIG_FRAC_BITS - 1);

   logic signed [TW-1:0] lut_sin;
   logic signed [TW-1:0] lut_cos;

   logic signed [TW-1:0] cos_x_ff, sin_x_ff, cos_y_ff, sin_y_ff;
   logic                 busy_ff;

   logic                 v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic                 accept;

   logic signed [P1W-1:0] p_yc_ff, p_zs_ff, p_ys_ff, p_zc_ff;
   logic signed [P1W-1:0] p_yc_in, p_zs_in, p_ys_in, p_zc_in;
   logic signed [W-1:0]   x1_ff, x2_ff;

   logic signed [S1W-1:0] y1_sum, z1_sum, y1_rnd, z1_rnd;
   logic signed [Y1W-1:0] y1_in, z1_in;
   logic signed [Y1W-1:0] y1_ff, z1_ff, y1_s3_ff;

   logic signed [P2W-1:0] p_xc_ff, p_z1s_ff, p_z1c_ff, p_xs_ff;
   logic signed [P2W-1:0] p_xc_in, p_z1s_in, p_z1c_in, p_xs_in;

   logic signed [S2W-1:0] rx_sum, rz_sum, rx_rnd, rz_rnd;
   logic signed [W-1:0]   rx_in, ry_in, rz_in;
   logic signed [W-1:0]   rx_ff, ry_ff, rz_ff;

   vrxy_trig_lut #(
      .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
   ) u_trig_lut (
      .angle   (csr_wdata),
      .sin_val (lut_sin),
      .cos_val (lut_cos)
   );

   assign accept = start && !busy;
   assign busy   = busy_ff | reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         cos_x_ff <= TrigOne;
         sin_x_ff <= '0;
         cos_y_ff <= TrigOne;
         sin_y_ff <= '0;
      end else begin
         busy_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               vrxy_pkg::CsrAngleX: begin
                  cos_x_ff <= lut_cos;
                  sin_x_ff <= lut_sin;
               end
               vrxy_pkg::CsrAngleY: begin
                  cos_y_ff <= lut_cos;
                  sin_y_ff <= lut_sin;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      p_yc_in = P1W'(req_vy) * P1W'(cos_x_ff);
      p_zs_in = P1W'(req_vz) * P1W'(sin_x_ff);
      p_ys_in = P1W'(req_vy) * P1W'(sin_x_ff);
      p_zc_in = P1W'(req_vz) * P1W'(cos_x_ff);

      y1_sum = S1W'(p_yc_ff) - S1W'(p_zs_ff);
      z1_sum = S1W'(p_ys_ff) + S1W'(p_zc_ff);
      y1_rnd = (y1_sum + Half1) >>> TRIG_FRAC_BITS;
      z1_rnd = (z1_sum + Half1) >>> TRIG_FRAC_BITS;
      y1_in  = y1_rnd[Y1W-1:0];
      z1_in  = z1_rnd[Y1W-1:0];

      p_xc_in  = P2W'(x2_ff) * P2W'(cos_y_ff);
      p_z1s_in = P2W'(z1_ff) * P2W'(sin_y_ff);
      p_z1c_in = P2W'(z1_ff) * P2W'(cos_y_ff);
      p_xs_in  = P2W'(x2_ff) * P2W'(sin_y_ff);

      rx_sum = S2W'(p_xc_ff) + S2W'(p_z1s_ff);
      rz_sum = S2W'(p_z1c_ff) - S2W'(p_xs_ff);
      rx_rnd = (rx_sum + Half2) >>> TRIG_FRAC_BITS;
      rz_rnd = (rz_sum + Half2) >>> TRIG_FRAC_BITS;

      if (rx_rnd[S2W-1:W-1] == {(S2W-W+1){rx_rnd[S2W-1]}}) begin
         rx_in = rx_rnd[W-1:0];
      end else begin
         rx_in = {rx_rnd[S2W-1], {(W-1){~rx_rnd[S2W-1]}}};
      end
      if (rz_rnd[S2W-1:W-1] == {(S2W-W+1){rz_rnd[S2W-1]}}) begin
         rz_in = rz_rnd[W-1:0];
      end else begin
         rz_in = {rz_rnd[S2W-1], {(W-1){~rz_rnd[S2W-1]}}};
      end
      if (y1_s3_ff[Y1W-1:W-1] == {(Y1W-W+1){y1_s3_ff[Y1W-1]}}) begin
         ry_in = y1_s3_ff[W-1:0];
      end else begin
         ry_in = {y1_s3_ff[Y1W-1], {(W-1){~y1_s3_ff[Y1W-1]}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= accept;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_yc_ff  <= p_yc_in;
      p_zs_ff  <= p_zs_in;
      p_ys_ff  <= p_ys_in;
      p_zc_ff  <= p_zc_in;
      x1_ff    <= req_vx;
      y1_ff    <= y1_in;
      z1_ff    <= z1_in;
      x2_ff    <= x1_ff;
      p_xc_ff  <= p_xc_in;
      p_z1s_ff <= p_z1s_in;
      p_z1c_ff <= p_z1c_in;
      p_xs_ff  <= p_xs_in;
      y1_s3_ff <= y1_ff;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      rz_ff    <= rz_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rx    = rx_ff;
   assign rsp_ry    = ry_ff;
   assign rsp_rz    = rz_ff;

endmodule

`default_nettype wire

// ----- design/vrxy_checker.sv -----
// Port-level checker for the vertex rotate unit, bound to the top level.
`default_nettype none

module vrxy_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid
);

   logic accept;

   assign accept = start && !busy;

   // every response beat comes from a matching earlier request beat
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 4))
      else $error("response beat without a matching request");

   // a request beat not cut by reset always gives its response
   a_req_gives_rsp: assert property (@(posedge clock)
      $past(accept, 4) && !$past(reset, 3) && !$past(reset, 2) && !$past(reset, 1)
      && !reset |-> rsp_valid)
      else $error("request beat lost");

   // reset drops pending beats and holds off requests right after it
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> busy && !rsp_valid)
      else $error("pipeline not cleared by reset");

endmodule

bind vertex_rotate_x_then_y_unit vrxy_checker u_vrxy_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

`default_nettype wire
